// ===== hw/rtl/mmrs_pkg.sv =====
package mmrs_pkg;

  // Field widths.
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned SCALE_W = 40;
  localparam int unsigned SC_W    = 30;

  // Pipeline shape: total depth, sine/cosine depth and divider depth.
  localparam int unsigned NUM_STAGES = 19;
  localparam int unsigned SC_STAGES  = 13;
  localparam int unsigned DIV_STAGES = 5;
  localparam int unsigned DIV_W      = 40;
  localparam int unsigned DIV_STEP   = DIV_W / DIV_STAGES;

  // Stages at which the scales are formed and last read.
  localparam int unsigned SCL_FIRST = 5;
  localparam int unsigned SCL_LAST  = 15;

  // Render class and destination codes.
  localparam logic [1:0] CLASS_IMAGE = 2'd0;
  localparam logic [1:0] CLASS_MODEL = 2'd1;

  typedef enum logic [1:0] {
    DEST_IMAGE    = 2'd0,
    DEST_MODEL    = 2'd1,
    DEST_UNROUTED = 2'd2
  } dest_e;

  // Angle constants in Q28.
  localparam logic [28:0] Q28_ONE    = 29'd268435456;
  localparam logic [30:0] Q28_PI_4   = 31'd210828714;
  localparam logic [30:0] Q28_PI_2   = 31'd421657428;
  localparam logic [30:0] Q28_TWO_PI = 31'd1686629713;

  // Quadrant thresholds: the angle reaches quadrant j at j*pi/2 - pi/4.
  localparam logic [30:0] K_THR_1 = 31'(1 * 64'd421657428 - 64'd210828714);
  localparam logic [30:0] K_THR_2 = 31'(2 * 64'd421657428 - 64'd210828714);
  localparam logic [30:0] K_THR_3 = 31'(3 * 64'd421657428 - 64'd210828714);
  localparam logic [30:0] K_THR_4 = 31'(4 * 64'd421657428 - 64'd210828714);

  // Reciprocal multipliers for exact floor division of 28-bit values.
  localparam int unsigned MAG_SH_72 = 28 + $clog2(72);
  localparam int unsigned MAG_SH_42 = 28 + $clog2(42);
  localparam int unsigned MAG_SH_20 = 28 + $clog2(20);
  localparam int unsigned MAG_SH_6  = 28 + $clog2(6);
  localparam int unsigned MAG_SH_90 = 28 + $clog2(90);
  localparam int unsigned MAG_SH_56 = 28 + $clog2(56);
  localparam int unsigned MAG_SH_30 = 28 + $clog2(30);
  localparam int unsigned MAG_SH_12 = 28 + $clog2(12);

  localparam logic [28:0] MAG_M_72 = 29'(((64'd1 << MAG_SH_72) + 64'd71) / 64'd72);
  localparam logic [28:0] MAG_M_42 = 29'(((64'd1 << MAG_SH_42) + 64'd41) / 64'd42);
  localparam logic [28:0] MAG_M_20 = 29'(((64'd1 << MAG_SH_20) + 64'd19) / 64'd20);
  localparam logic [28:0] MAG_M_6  = 29'(((64'd1 << MAG_SH_6) + 64'd5) / 64'd6);
  localparam logic [28:0] MAG_M_90 = 29'(((64'd1 << MAG_SH_90) + 64'd89) / 64'd90);
  localparam logic [28:0] MAG_M_56 = 29'(((64'd1 << MAG_SH_56) + 64'd55) / 64'd56);
  localparam logic [28:0] MAG_M_30 = 29'(((64'd1 << MAG_SH_30) + 64'd29) / 64'd30);
  localparam logic [28:0] MAG_M_12 = 29'(((64'd1 << MAG_SH_12) + 64'd11) / 64'd12);

  // Payload that travels alongside the arithmetic.
  typedef struct packed {
    logic [7:0]        obj;
    logic [1:0]        cls;
    logic [1:0]        row;
    logic [15:0]       u;
    logic [15:0]       ar;
    logic [23:0]       w;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic [ELEM_W-1:0] c;
    logic [ELEM_W-1:0] d;
  } pay_t;

  // Floor division of a value below 2**28 by a constant, via its reciprocal.
  function automatic logic [27:0] div_magic(input logic [27:0] n, input logic [28:0] m,
                                            input int unsigned sh);
    logic [56:0] prod;
    prod = {29'd0, n} * {28'd0, m};
    return 28'(prod >> sh);
  endfunction

endpackage

// ===== hw/rtl/model_matrix_rotate_scale.sv =====
// Throughput: one matrix row per cycle while the output is not stalled; every stage
// is fully pipelined, the longest chains being the 13-stage sine/cosine unit and the
// 5-stage restoring divider.
// A stall on the output holds only the stages that are full, so bubbles close up.
// Reset clears all valid bits and sets aspect_ratio to 1.0 (256); payload is not reset.
module model_matrix_rotate_scale import mmrs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               object_index_i,
  input  logic [1:0]               render_class_i,
  input  logic signed [15:0]       rotation_angle_i,
  input  logic [15:0]              scale_factor_i,
  input  logic [1:0]               row_index_i,
  input  logic signed [ELEM_W-1:0] in_elem_0_i,
  input  logic signed [ELEM_W-1:0] in_elem_1_i,
  input  logic signed [ELEM_W-1:0] in_elem_2_i,
  input  logic signed [ELEM_W-1:0] in_elem_3_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               out_object_index_o,
  output logic [1:0]               destination_o,
  output logic [1:0]               out_row_index_o,
  output logic signed [ELEM_W-1:0] out_elem_0_o,
  output logic signed [ELEM_W-1:0] out_elem_1_o,
  output logic signed [ELEM_W-1:0] out_elem_2_o,
  output logic signed [ELEM_W-1:0] out_elem_3_o,
  output logic                     saturated_o
);

  localparam int unsigned LAST = NUM_STAGES - 1;

  logic [15:0]           aspect_q;
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;
  pay_t                  pay_q [NUM_STAGES];
  pay_t                  pay_d;

  // Aspect ratio register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aspect_q <= 16'd256;
    end else if (cfg_we_i) begin
      aspect_q <= cfg_wdata_i;
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[LAST] = !vld_q[LAST] || !out_stall_i;
    for (int k = int'(LAST) - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Payload capture and delay line.
  always_comb begin
    pay_d.obj = object_index_i;
    pay_d.cls = render_class_i;
    pay_d.row = row_index_i;
    pay_d.u   = scale_factor_i;
    pay_d.ar  = (aspect_q == '0) ? 16'd1 : aspect_q;
    pay_d.w   = {8'd0, scale_factor_i} * 24'd160;
    pay_d.a   = in_elem_0_i;
    pay_d.b   = in_elem_1_i;
    pay_d.c   = in_elem_2_i;
    pay_d.d   = in_elem_3_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pay_q[0] <= pay_d;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        pay_q[k] <= pay_q[k-1];
      end
    end
  end

  // Sine and cosine of the rotation angle.
  logic signed [SC_W-1:0] sin_w;
  logic signed [SC_W-1:0] cos_w;

  mmrs_sincos u_sincos (
    .clk_i   (clk_i),
    .en_i    (en[SC_STAGES-1:0]),
    .angle_i (rotation_angle_i),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  // Stretched y scale for a ratio below one: 160*u*65536 / ratio.
  logic [DIV_W-1:0] quo_w;

  mmrs_div u_div (
    .clk_i (clk_i),
    .en_i  (en[DIV_STAGES-1:0]),
    .num_i ({pay_d.w, 16'd0}),
    .den_i (pay_d.ar[7:0]),
    .quo_o (quo_w)
  );

  // Per-axis scales in Q16, formed once the quotient is ready.
  logic [SCALE_W-1:0] scl_q [SCL_FIRST:SCL_LAST][3];
  logic [SCALE_W-1:0] scl_d [3];
  logic [SCALE_W-1:0] stretch;
  logic [SCALE_W-1:0] base_img;

  always_comb begin
    stretch  = {16'd0, pay_q[SCL_FIRST-1].w} * {24'd0, pay_q[SCL_FIRST-1].ar};
    base_img = {8'd0, pay_q[SCL_FIRST-1].w, 8'd0};
    case (pay_q[SCL_FIRST-1].cls)
      CLASS_IMAGE: begin
        scl_d[2] = base_img;
        if (pay_q[SCL_FIRST-1].ar >= 16'd256) begin
          scl_d[0] = stretch;
          scl_d[1] = base_img;
        end else begin
          scl_d[0] = base_img;
          scl_d[1] = quo_w;
        end
      end
      CLASS_MODEL: begin
        scl_d[0] = {13'd0, {3'd0, pay_q[SCL_FIRST-1].u} * 19'd5, 8'd0};
        scl_d[1] = scl_d[0];
        scl_d[2] = scl_d[0];
      end
      default: begin
        scl_d[0] = {16'd0, pay_q[SCL_FIRST-1].u, 8'd0};
        scl_d[1] = scl_d[0];
        scl_d[2] = scl_d[0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[SCL_FIRST]) begin
      scl_q[SCL_FIRST] <= scl_d;
    end
    for (int k = SCL_FIRST + 1; k <= SCL_LAST; k++) begin
      if (en[k]) begin
        scl_q[k] <= scl_q[k-1];
      end
    end
  end

  // Rotation products.
  logic signed [61:0] pac_q;
  logic signed [61:0] pbs_q;
  logic signed [61:0] pas_q;
  logic signed [61:0] pbc_q;

  always_ff @(posedge clk_i) begin
    if (en[13]) begin
      pac_q <= $signed(pay_q[12].a) * cos_w;
      pbs_q <= $signed(pay_q[12].b) * sin_w;
      pas_q <= $signed(pay_q[12].a) * sin_w;
      pbc_q <= $signed(pay_q[12].b) * cos_w;
    end
  end

  // Rotated sums.
  logic signed [62:0] sum0_q;
  logic signed [62:0] sum2_q;

  always_ff @(posedge clk_i) begin
    if (en[14]) begin
      sum0_q <= pac_q - pbs_q;
      sum2_q <= pas_q + pbc_q;
    end
  end

  // Sign and magnitude of each entry before scaling; the middle one is -c.
  logic signed [62:0] mag0;
  logic signed [62:0] mag2;
  logic [32:0]        mag1;
  logic [32:0]        m_q   [3];
  logic               neg_q [15:17][3];

  always_comb begin
    mag0 = sum0_q[62] ? -sum0_q : sum0_q;
    mag2 = sum2_q[62] ? -sum2_q : sum2_q;
    mag1 = pay_q[14].c[31] ? 33'd0 - {1'b1, pay_q[14].c} : {1'b0, pay_q[14].c};
  end

  always_ff @(posedge clk_i) begin
    if (en[15]) begin
      m_q[0]       <= mag0[60:28];
      m_q[1]       <= mag1;
      m_q[2]       <= mag2[60:28];
      neg_q[15][0] <= sum0_q[62];
      neg_q[15][1] <= !pay_q[14].c[31] && (pay_q[14].c != '0);
      neg_q[15][2] <= sum2_q[62];
    end
    for (int k = 16; k <= 17; k++) begin
      if (en[k]) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // Scaling: split product, recombination, then clamp.
  logic [52:0]       lo_q   [3];
  logic [52:0]       hi_q   [3];
  logic [72:0]       prod_q [3];
  logic [ELEM_W-1:0] res_d  [3];
  logic [2:0]        sat_e;
  logic [ELEM_W-1:0] elem_q [3];
  logic              sat_q;

  for (genvar e = 0; e < 3; e++) begin : g_elem
    logic [56:0] pmag;

    always_ff @(posedge clk_i) begin
      if (en[16]) begin
        lo_q[e] <= {20'd0, m_q[e]} * {33'd0, scl_q[SCL_LAST][e][19:0]};
        hi_q[e] <= {20'd0, m_q[e]} * {33'd0, scl_q[SCL_LAST][e][39:20]};
      end
      if (en[17]) begin
        prod_q[e] <= {hi_q[e], 20'd0} + {20'd0, lo_q[e]};
      end
    end

    always_comb begin
      pmag = prod_q[e][72:16];
      if (neg_q[17][e]) begin
        sat_e[e] = pmag > 57'h0_0000_8000_0000;
        res_d[e] = sat_e[e] ? 32'h8000_0000 : 32'd0 - pmag[31:0];
      end else begin
        sat_e[e] = pmag > 57'h0_0000_7FFF_FFFF;
        res_d[e] = sat_e[e] ? 32'h7FFF_FFFF : pmag[31:0];
      end
    end
  end

  // Output register; the last row passes through.
  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      if (pay_q[LAST-1].row == 2'd3) begin
        elem_q[0] <= pay_q[LAST-1].a;
        elem_q[1] <= pay_q[LAST-1].b;
        elem_q[2] <= pay_q[LAST-1].c;
        sat_q     <= 1'b0;
      end else begin
        elem_q <= res_d;
        sat_q  <= |sat_e;
      end
    end
  end

  always_comb begin
    case (pay_q[LAST].cls)
      CLASS_IMAGE: destination_o = DEST_IMAGE;
      CLASS_MODEL: destination_o = DEST_MODEL;
      default:     destination_o = DEST_UNROUTED;
    endcase
  end

  assign out_valid_o        = vld_q[LAST];
  assign out_object_index_o = pay_q[LAST].obj;
  assign out_row_index_o    = pay_q[LAST].row;
  assign out_elem_0_o       = elem_q[0];
  assign out_elem_1_o       = elem_q[1];
  assign out_elem_2_o       = elem_q[2];
  assign out_elem_3_o       = pay_q[LAST].d;
  assign saturated_o        = sat_q;

  // The input stalls only when every stage holds an item and the output is held.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  // A saturated result carries at least one clamped entry.
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      out_elem_0_o == 32'sh7FFF_FFFF || out_elem_0_o == 32'sh8000_0000 ||
      out_elem_1_o == 32'sh7FFF_FFFF || out_elem_1_o == 32'sh8000_0000 ||
      out_elem_2_o == 32'sh7FFF_FFFF || out_elem_2_o == 32'sh8000_0000)
    else $error("saturation flagged without a clamped entry");

  // The last row never saturates.
  a_row3_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_row_index_o == 2'd3 |-> !saturated_o)
    else $error("passed-through row flagged as saturated");

  // A held result keeps its first entry and saturation flag while the output is stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_elem_0_o)
      && $stable(saturated_o))
    else $error("result changed under stall");

endmodule

// ===== hw/rtl/mmrs_div.sv =====
module mmrs_div import mmrs_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [DIV_W-1:0]      num_i,
  input  logic [7:0]            den_i,
  output logic [DIV_W-1:0]      quo_o
);

  // Restoring division, a fixed number of quotient bits per stage.
  logic [7:0]       rem_q [DIV_STAGES];
  logic [DIV_W-1:0] num_q [DIV_STAGES];
  logic [DIV_W-1:0] quo_q [DIV_STAGES];
  logic [7:0]       den_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [7:0]       rem_in;
    logic [DIV_W-1:0] num_in;
    logic [DIV_W-1:0] quo_in;
    logic [7:0]       den_in;
    logic [7:0]       rem_d;
    logic [DIV_W-1:0] num_d;
    logic [DIV_W-1:0] quo_d;
    logic [8:0]       trial;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Shift in one numerator bit per step and subtract where it fits.
    always_comb begin
      rem_d = rem_in;
      num_d = num_in;
      quo_d = quo_in;
      trial = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
        trial = {rem_d, num_d[DIV_W-1]};
        num_d = {num_d[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_d = 8'(trial - {1'b0, den_in});
          quo_d = {quo_d[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = trial[7:0];
          quo_d = {quo_d[DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        num_q[k] <= num_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// ===== hw/rtl/mmrs_sincos.sv =====
module mmrs_sincos import mmrs_pkg::*; (
  input  logic                   clk_i,
  input  logic [SC_STAGES-1:0]   en_i,
  input  logic signed [15:0]     angle_i,
  output logic signed [SC_W-1:0] sin_o,
  output logic signed [SC_W-1:0] cos_o
);

  localparam logic signed [33:0] TWO_PI_S = $signed({3'b000, Q28_TWO_PI});

  localparam logic [28:0]  SIN_M  [3] = '{MAG_M_42, MAG_M_20, MAG_M_6};
  localparam int unsigned  SIN_SH [3] = '{MAG_SH_42, MAG_SH_20, MAG_SH_6};
  localparam logic [28:0]  COS_M  [3] = '{MAG_M_56, MAG_M_30, MAG_M_12};
  localparam int unsigned  COS_SH [3] = '{MAG_SH_56, MAG_SH_30, MAG_SH_12};

  // Unsigned Q28 product, truncated; it never exceeds x while y is at most 1.0.
  function automatic logic [27:0] mul_q28(input logic [27:0] x, input logic [28:0] y);
    logic [56:0] p;
    p = {29'd0, x} * {28'd0, y};
    return p[55:28];
  endfunction

  logic [30:0]            zr_q;
  logic [27:0]            x_q    [1:9];
  logic [27:0]            sq_q   [2:9];
  logic                   rneg_q [1:10];
  logic [1:0]             kq_q   [1:11];
  logic [28:0]            sp_q   [4];
  logic [28:0]            cp_q   [4];
  logic [27:0]            st_q   [3];
  logic [27:0]            ct_q   [3];
  logic [27:0]            srm_q;
  logic [27:0]            cft_q;
  logic signed [SC_W-1:0] sr_q;
  logic signed [SC_W-1:0] cr_q;
  logic signed [SC_W-1:0] s_q;
  logic signed [SC_W-1:0] c_q;

  // Reduce the angle into one turn.
  logic signed [33:0] z;
  logic signed [33:0] zr_d;

  always_comb begin
    z = {{2{angle_i[15]}}, angle_i, 16'd0};
    if (z < -TWO_PI_S) begin
      zr_d = z + TWO_PI_S + TWO_PI_S;
    end else if (z < 34'sd0) begin
      zr_d = z + TWO_PI_S;
    end else if (z >= TWO_PI_S) begin
      zr_d = z - TWO_PI_S;
    end else begin
      zr_d = z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zr_q <= zr_d[30:0];
    end
  end

  // Split into quadrant and remainder within a quarter turn of it.
  logic [2:0]         kc;
  logic [30:0]        k_off;
  logic signed [31:0] rem;

  always_comb begin
    kc = 3'(zr_q >= K_THR_1) + 3'(zr_q >= K_THR_2) + 3'(zr_q >= K_THR_3)
       + 3'(zr_q >= K_THR_4);
    case (kc)
      3'd0:    k_off = '0;
      3'd1:    k_off = Q28_PI_2;
      3'd2:    k_off = 31'(2 * 64'd421657428);
      3'd3:    k_off = 31'(3 * 64'd421657428);
      default: k_off = 31'(4 * 64'd421657428);
    endcase
    rem = $signed({1'b0, zr_q}) - $signed({1'b0, k_off});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_q[1]    <= rem[31] ? 28'(-rem) : rem[27:0];
      rneg_q[1] <= rem[31];
      kq_q[1]   <= kc[1:0];
    end
  end

  // Square of the remainder.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sq_q[2] <= mul_q28(x_q[1], {1'b0, x_q[1]});
    end
  end

  // Carry the remainder, its square, its sign and the quadrant.
  for (genvar k = 2; k <= 9; k++) begin : g_xcarry
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        x_q[k] <= x_q[k-1];
      end
    end
  end
  for (genvar k = 3; k <= 9; k++) begin : g_sqcarry
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        sq_q[k] <= sq_q[k-1];
      end
    end
  end
  for (genvar k = 2; k <= 10; k++) begin : g_scarry
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rneg_q[k] <= rneg_q[k-1];
      end
    end
  end
  for (genvar k = 2; k <= 11; k++) begin : g_kcarry
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        kq_q[k] <= kq_q[k-1];
      end
    end
  end

  // Innermost Horner terms of both series.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sp_q[0] <= Q28_ONE - {1'b0, div_magic(sq_q[2], MAG_M_72, MAG_SH_72)};
      cp_q[0] <= Q28_ONE - {1'b0, div_magic(sq_q[2], MAG_M_90, MAG_SH_90)};
    end
  end

  // Remaining Horner steps: a product stage, then a division stage.
  for (genvar j = 0; j < 3; j++) begin : g_horner
    always_ff @(posedge clk_i) begin
      if (en_i[4+2*j]) begin
        st_q[j] <= mul_q28(sq_q[3+2*j], sp_q[j]);
        ct_q[j] <= mul_q28(sq_q[3+2*j], cp_q[j]);
      end
      if (en_i[5+2*j]) begin
        sp_q[j+1] <= Q28_ONE - {1'b0, div_magic(st_q[j], SIN_M[j], SIN_SH[j])};
        cp_q[j+1] <= Q28_ONE - {1'b0, div_magic(ct_q[j], COS_M[j], COS_SH[j])};
      end
    end
  end

  // Sine takes its final factor of x; cosine takes its last term.
  always_ff @(posedge clk_i) begin
    if (en_i[10]) begin
      srm_q <= mul_q28(x_q[9], sp_q[3]);
      cft_q <= mul_q28(sq_q[9], cp_q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[11]) begin
      sr_q <= rneg_q[10] ? -$signed({2'b00, srm_q}) : $signed({2'b00, srm_q});
      cr_q <= $signed({1'b0, Q28_ONE - {2'b00, cft_q[27:1]}});
    end
  end

  // Quadrant swaps and negates.
  always_ff @(posedge clk_i) begin
    if (en_i[12]) begin
      case (kq_q[11])
        2'd0: begin
          s_q <= sr_q;
          c_q <= cr_q;
        end
        2'd1: begin
          s_q <= cr_q;
          c_q <= -sr_q;
        end
        2'd2: begin
          s_q <= -sr_q;
          c_q <= -cr_q;
        end
        default: begin
          s_q <= -cr_q;
          c_q <= sr_q;
        end
      endcase
    end
  end

  assign sin_o = s_q;
  assign cos_o = c_q;

endmodule

// ===== sim/tb_model_matrix_rotate_scale.sv =====
module tb_model_matrix_rotate_scale;
  import mmrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_DEPTH = NUM_STAGES;

  localparam longint ANG_ONE    = 64'sd268435456;
  localparam longint ANG_PI_4   = 64'sd210828714;
  localparam longint ANG_PI_2   = 64'sd421657428;
  localparam longint ANG_TWO_PI = 64'sd1686629713;

  // One matrix row as presented on the input.
  typedef struct {
    logic [7:0]         obj;
    logic [1:0]         cls;
    logic signed [15:0] ang;
    logic [15:0]        u;
    logic [1:0]         row;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
    logic signed [31:0] e3;
  } row_item_t;

  // One transformed row as expected on the output.
  typedef struct {
    logic [7:0]  obj;
    dest_e       dest;
    logic [1:0]  row;
    logic [31:0] e0;
    logic [31:0] e1;
    logic [31:0] e2;
    logic [31:0] e3;
    logic        sat;
  } row_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] object_index_i = '0;
  logic [1:0] render_class_i = '0;
  logic signed [15:0] rotation_angle_i = '0;
  logic [15:0] scale_factor_i = '0;
  logic [1:0] row_index_i = '0;
  logic signed [31:0] in_elem_0_i = '0;
  logic signed [31:0] in_elem_1_i = '0;
  logic signed [31:0] in_elem_2_i = '0;
  logic signed [31:0] in_elem_3_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_object_index_o;
  logic [1:0] destination_o;
  logic [1:0] out_row_index_o;
  logic signed [31:0] out_elem_0_o;
  logic signed [31:0] out_elem_1_o;
  logic signed [31:0] out_elem_2_o;
  logic signed [31:0] out_elem_3_o;
  logic saturated_o;

  model_matrix_rotate_scale dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .object_index_i, .render_class_i, .rotation_angle_i, .scale_factor_i, .row_index_i,
    .in_elem_0_i, .in_elem_1_i, .in_elem_2_i, .in_elem_3_i,
    .out_valid_o, .out_stall_i,
    .out_object_index_o, .destination_o, .out_row_index_o,
    .out_elem_0_o, .out_elem_1_o, .out_elem_2_o, .out_elem_3_o, .saturated_o
  );

  always #1 clk_i = ~clk_i;

  row_item_t   rows_to_send[$];
  row_result_t rows_expected[$];
  logic [15:0] aspect_q8;
  int unsigned mismatches = 0;
  int unsigned rows_checked = 0;
  int unsigned rows_clamped = 0;
  int unsigned ratios_used = 0;

  // Sine and cosine of a Q3.12 angle in Q28, by quadrant and Taylor series.
  function automatic void angle_sincos(input logic signed [15:0] ang,
                                       output longint sin_q, output longint cos_q);
    longint z, k, r, x, x2, p, sr, cr;
    z = longint'(ang) * 65536;
    while (z < 0) z += ANG_TWO_PI;
    while (z >= ANG_TWO_PI) z -= ANG_TWO_PI;
    k = (z + ANG_PI_4) / ANG_PI_2;
    r = z - k * ANG_PI_2;
    x = (r < 0) ? -r : r;
    x2 = (x * x) >>> 28;
    p = ANG_ONE - x2 / 72;
    p = ANG_ONE - ((x2 * p) >>> 28) / 42;
    p = ANG_ONE - ((x2 * p) >>> 28) / 20;
    p = ANG_ONE - ((x2 * p) >>> 28) / 6;
    sr = (x * p) >>> 28;
    if (r < 0) sr = -sr;
    p = ANG_ONE - x2 / 90;
    p = ANG_ONE - ((x2 * p) >>> 28) / 56;
    p = ANG_ONE - ((x2 * p) >>> 28) / 30;
    p = ANG_ONE - ((x2 * p) >>> 28) / 12;
    cr = ANG_ONE - ((x2 * p) >>> 28) / 2;
    case (k & 3)
      0: begin sin_q = sr;  cos_q = cr;  end
      1: begin sin_q = cr;  cos_q = -sr; end
      2: begin sin_q = -sr; cos_q = -cr; end
      default: begin sin_q = -cr; cos_q = sr; end
    endcase
  endfunction

  // Drop 28 fraction bits, rounding toward zero.
  function automatic longint trunc_q28(input longint t);
    longint unsigned m;
    m = (t < 0) ? longint'(-t) : t;
    m = m >> 28;
    return (t < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Apply a Q16 scale, round toward zero and clamp to the 32-bit range.
  function automatic logic [31:0] scale_clamp(input longint v, input longint unsigned s,
                                              inout logic sat);
    longint unsigned m, p;
    m = (v < 0) ? longint'(-v) : v;
    if (m != 0 && s > (64'd1 << 62) / m) begin
      sat = 1'b1;
      return (v < 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    p = (m * s) >> 16;
    if (v < 0) begin
      if (p > 64'd2147483648) begin sat = 1'b1; p = 64'd2147483648; end
      return 32'(-longint'(p));
    end
    if (p > 64'd2147483647) begin sat = 1'b1; p = 64'd2147483647; end
    return 32'(p);
  endfunction

  // Expected transformed row for one input row under the current ratio.
  function automatic row_result_t transform_row(input row_item_t it, input logic [15:0] ratio);
    row_result_t res;
    longint unsigned sx, sy, sz, ar, u;
    longint s0, c0, a, b, c;
    logic sat;
    res.obj = it.obj;
    res.dest = (it.cls == CLASS_IMAGE) ? DEST_IMAGE :
               (it.cls == CLASS_MODEL) ? DEST_MODEL : DEST_UNROUTED;
    res.row = it.row;
    res.e3 = it.e3;
    if (it.row == 2'd3) begin
      res.e0 = it.e0;
      res.e1 = it.e1;
      res.e2 = it.e2;
      res.sat = 1'b0;
      return res;
    end
    u = 64'(it.u);
    if (it.cls == CLASS_IMAGE) begin
      ar = (ratio == 16'd0) ? 64'd1 : 64'(ratio);
      sz = 160 * u * 256;
      if (ar >= 256) begin
        sx = 160 * u * ar;
        sy = sz;
      end else begin
        sx = sz;
        sy = (160 * u * 65536) / ar;
      end
    end else if (it.cls == CLASS_MODEL) begin
      sx = 5 * u * 256; sy = sx; sz = sx;
    end else begin
      sx = u * 256; sy = sx; sz = sx;
    end
    angle_sincos(it.ang, s0, c0);
    a = it.e0; b = it.e1; c = it.e2;
    sat = 1'b0;
    res.e0 = scale_clamp(trunc_q28(a * c0 - b * s0), sx, sat);
    res.e1 = scale_clamp(-c, sy, sat);
    res.e2 = scale_clamp(trunc_q28(a * s0 + b * c0), sz, sat);
    res.sat = sat;
    return res;
  endfunction

  // Matrix entries: mostly moderate values, with extremes and full-range noise.
  function automatic logic signed [31:0] pick_entry();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3, 4: return $urandom;
      default: return 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic row_item_t random_row();
    row_item_t it;
    it.obj = 8'($urandom);
    it.cls = 2'($urandom_range(0, 3));
    it.row = 2'($urandom_range(0, 3));
    it.ang = ($urandom_range(0, 7) == 0) ? 16'(signed'($urandom_range(0, 64)) - 32)
                                         : 16'($urandom);
    case ($urandom_range(0, 5))
      0: it.u = 16'($urandom);
      1: it.u = ($urandom_range(0, 1)) ? 16'hffff : 16'h0000;
      default: it.u = 16'($urandom_range(0, 1024));
    endcase
    it.e0 = pick_entry();
    it.e1 = pick_entry();
    it.e2 = pick_entry();
    it.e3 = $urandom;
    return it;
  endfunction

  function automatic row_item_t make_row(input logic [1:0] cls, input logic [1:0] row,
                                         input logic signed [15:0] ang, input logic [15:0] u,
                                         input logic signed [31:0] v);
    row_item_t it;
    it.obj = 8'($urandom);
    it.cls = cls; it.row = row; it.ang = ang; it.u = u;
    it.e0 = v; it.e1 = -v; it.e2 = v; it.e3 = ~v;
    return it;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    row_item_t nxt;
    row_item_t cur;
    if (in_valid_i && !in_stall_o) begin
      cur.obj = object_index_i; cur.cls = render_class_i; cur.ang = rotation_angle_i;
      cur.u = scale_factor_i; cur.row = row_index_i;
      cur.e0 = in_elem_0_i; cur.e1 = in_elem_1_i; cur.e2 = in_elem_2_i; cur.e3 = in_elem_3_i;
      rows_expected.push_back(transform_row(cur, aspect_q8));
    end
    if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (rows_to_send.size() != 0) begin
        nxt = rows_to_send.pop_front();
        in_valid_i <= 1'b1;
        object_index_i <= nxt.obj; render_class_i <= nxt.cls; rotation_angle_i <= nxt.ang;
        scale_factor_i <= nxt.u; row_index_i <= nxt.row;
        in_elem_0_i <= nxt.e0; in_elem_1_i <= nxt.e1;
        in_elem_2_i <= nxt.e2; in_elem_3_i <= nxt.e3;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall behaviour switches between free-running, random and blocked spells.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 25) : $urandom_range(5, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= 1'b1;
    endcase
  end

  // Monitor: every output transfer against the oldest expected row.
  always @(posedge clk_i) begin
    row_result_t want;
    logic bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rows_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output row, object %0d row %0d",
                                       out_object_index_o, out_row_index_o);
      end else begin
        want = rows_expected.pop_front();
        rows_checked++;
        if (want.sat) rows_clamped++;
        bad = (out_object_index_o !== want.obj) || (destination_o !== want.dest) ||
              (out_row_index_o !== want.row) || (out_elem_0_o !== want.e0) ||
              (out_elem_1_o !== want.e1) || (out_elem_2_o !== want.e2) ||
              (out_elem_3_o !== want.e3) || (saturated_o !== want.sat);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: row %0d obj/dest/row/sat exp %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                     rows_checked, want.obj, want.dest, want.row, want.sat,
                     out_object_index_o, destination_o, out_row_index_o, saturated_o);
            $display("       entries exp %h %h %h %h got %h %h %h %h",
                     want.e0, want.e1, want.e2, want.e3,
                     out_elem_0_o, out_elem_1_o, out_elem_2_o, out_elem_3_o);
          end
        end
      end
    end
  end

  // Wait for the sender to empty and every expected row to arrive, then let the pipe settle.
  task automatic drain_rows();
    wait (rows_to_send.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i && rows_expected.size() == 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [15:0] ratio);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ratio;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    aspect_q8 = ratio;
    ratios_used++;
  endtask

  // Stimulus: directed and random rows at the reset ratio, then random rows per ratio.
  initial begin
    logic [15:0] ratios[8];
    aspect_q8 = 16'd256;
    ratios = '{16'd0, 16'd1, 16'hffff, 16'd255, 16'd128, 16'd512, 16'd256, 16'd0};
    ratios[7] = 16'($urandom_range(1, 65535));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Every class and row, the extremes of angle, scale and entries, and a pass-through row.
    for (int cl = 0; cl < 4; cl++) begin
      rows_to_send.push_back(make_row(2'(cl), 2'd0, 16'sh0000, 16'h0100, 32'sh0001_0000));
      rows_to_send.push_back(make_row(2'(cl), 2'd1, 16'sh7fff, 16'hffff, 32'sh7fff_ffff));
      rows_to_send.push_back(make_row(2'(cl), 2'd2, -16'sh8000, 16'h0000, 32'sh8000_0000));
      rows_to_send.push_back(make_row(2'(cl), 2'd3, 16'sh1922, 16'hffff, 32'sh8000_0000));
    end
    rows_to_send.push_back(make_row(CLASS_IMAGE, 2'd0, 16'sh1922, 16'h0001, 32'sh0000_0001));
    rows_to_send.push_back(make_row(CLASS_IMAGE, 2'd2, -16'sh1922, 16'h0200, -32'sh0003_0000));
    rows_to_send.push_back(make_row(CLASS_MODEL, 2'd1, 16'sh0c91, 16'h8000, 32'sh0000_0000));
    rows_to_send[$].obj = 8'hff;
    rows_to_send.push_back(make_row(2'd2, 2'd0, 16'sh3244, 16'h0100, 32'sh7fff_0000));
    rows_to_send[$].obj = 8'h00;
    for (int n = 0; n < 100; n++) rows_to_send.push_back(random_row());
    drain_rows();

    // The sender holds off between phases while the ratio changes.
    foreach (ratios[i]) begin
      write_ratio(ratios[i]);
      for (int n = 0; n < 190; n++) rows_to_send.push_back(random_row());
      drain_rows();
    end

    $display("Checked %0d rows over %0d aspect ratio settings, %0d of them clamped.",
             rows_checked, ratios_used + 1, rows_clamped);
    if (mismatches == 0) begin
      $display("model_matrix_rotate_scale: match");
    end else begin
      $display("%0d mismatching rows.", mismatches);
      $display("model_matrix_rotate_scale: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #2_000_000;
    $display("Timed out with %0d rows still expected.", rows_expected.size());
    $display("model_matrix_rotate_scale: mismatch");
    $finish;
  end

endmodule
